// ===== hdl/l3d_pkg.sv =====
// Shared constants, types and helpers for the 3x3x3 Laplacian stencil filter.
package l3d_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int MAX_DEPTH   = 1024;

    localparam int CFG_W_BITS    = 7;
    localparam int CFG_H_BITS    = 7;
    localparam int CFG_D_BITS    = 11;
    localparam int CFG_DATA_BITS = 11;
    localparam int OUT_BITS      = 18;

    localparam int X_BITS          = $clog2(MAX_WIDTH);
    localparam int Y_BITS          = $clog2(MAX_HEIGHT);
    localparam int Z_BITS          = $clog2(MAX_DEPTH);
    localparam int PLANE_ADDR_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int LAG_BITS        = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);

    localparam int RST_WIDTH  = 4;
    localparam int RST_HEIGHT = 3;
    localparam int RST_DEPTH  = 5;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'b00,
        REG_HEIGHT = 2'b01,
        REG_DEPTH  = 2'b10
    } cfg_reg_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [2:0]          tap_row_t;
    typedef tap_row_t [2:0]         tap_plane_t;
    // index [j][r][c]: j=0 is the next slice, r=0 the next row, c=0 the next voxel
    typedef tap_plane_t [2:0]       window_t;

    // neighbor availability around the output voxel, plus end-of-volume flag
    typedef struct packed {
        logic last;
        logic x_dn;
        logic x_up;
        logic y_dn;
        logic y_up;
        logic z_dn;
        logic z_up;
    } bound_t;

    function automatic logic [CFG_D_BITS-1:0] clamp_dim(
        input logic [CFG_D_BITS-1:0] v,
        input logic [CFG_D_BITS-1:0] hi
    );
        logic [CFG_D_BITS-1:0] r;
        if (v == '0)
            r = CFG_D_BITS'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== hdl/l3d_delay_ram.sv =====
// Circular-buffer delay line with programmable length and registered read.
module l3d_delay_ram
    import l3d_pkg::*;
#(
    parameter int ADDR_BITS = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic [ADDR_BITS-1:0] delay,
    input  sample_t              din,
    output sample_t              dout
);

    sample_t                mem [2**ADDR_BITS];
    logic [ADDR_BITS-1:0]   wptr_reg;
    logic [ADDR_BITS-1:0]   raddr;
    sample_t                dout_reg;

    assign raddr = wptr_reg - delay;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wptr_reg <= '0;
        else if (adv)
            wptr_reg <= wptr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mem[wptr_reg] <= din;
            if (delay == '0)
                dout_reg <= din;
            else
                dout_reg <= mem[raddr];
        end
    end

    assign dout = dout_reg;

endmodule

// ===== hdl/l3d_window.sv =====
// 27-tap sliding window built from plane and row delay lines.
module l3d_window
    import l3d_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  sample_t                    sample,
    input  logic [X_BITS-1:0]          w_m1,
    input  logic [PLANE_ADDR_BITS-1:0] wh_m1,
    output window_t                    taps
);

    sample_t first_reg;
    sample_t lead      [3][3];
    sample_t trail_reg [3][3][2];

    assign lead[0][0] = first_reg;

    genvar gj, gr;
    generate
        for (gj = 1; gj < 3; gj++)
        begin : g_plane
            l3d_delay_ram #(.ADDR_BITS(PLANE_ADDR_BITS)) u_plane (
                .clk   (clk),
                .rst_n (rst_n),
                .adv   (adv),
                .delay (wh_m1),
                .din   (lead[gj-1][0]),
                .dout  (lead[gj][0])
            );
        end
        for (gj = 0; gj < 3; gj++)
        begin : g_rows
            for (gr = 1; gr < 3; gr++)
            begin : g_row
                l3d_delay_ram #(.ADDR_BITS(X_BITS)) u_row (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .adv   (adv),
                    .delay (w_m1),
                    .din   (lead[gj][gr-1]),
                    .dout  (lead[gj][gr])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            first_reg <= sample;
            for (int j = 0; j < 3; j++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    trail_reg[j][r][0] <= lead[j][r];
                    trail_reg[j][r][1] <= trail_reg[j][r][0];
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                taps[j][r][0] = lead[j][r];
                taps[j][r][1] = trail_reg[j][r][0];
                taps[j][r][2] = trail_reg[j][r][1];
            end
        end
    end

endmodule

// ===== hdl/l3d_seq.sv =====
// Volume registers, fill tracking and output voxel coordinates.
module l3d_seq
    import l3d_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                       adv,
    output logic                       produce,
    output bound_t                     bnd,
    output logic [X_BITS-1:0]          w_m1,
    output logic [PLANE_ADDR_BITS-1:0] wh_m1
);

    logic [CFG_W_BITS-1:0] width_reg, width_next;
    logic [CFG_H_BITS-1:0] height_reg, height_next;
    logic [CFG_D_BITS-1:0] depth_reg, depth_next;
    logic                  restart;

    logic [CFG_W_BITS-1:0]      w_c;
    logic [CFG_H_BITS-1:0]      h_c;
    logic [CFG_D_BITS-1:0]      d_c;
    logic [CFG_W_BITS+CFG_H_BITS-1:0] wh;

    logic [X_BITS-1:0]          w_m1_reg, w_m1_next;
    logic [Y_BITS-1:0]          h_m1_reg, h_m1_next;
    logic [Z_BITS-1:0]          d_m1_reg, d_m1_next;
    logic [PLANE_ADDR_BITS-1:0] wh_m1_reg, wh_m1_next;
    logic [LAG_BITS-1:0]        lag_reg, lag_next;

    logic [LAG_BITS-1:0] fill_reg, fill_next;
    logic                primed_reg, primed_next;
    logic [X_BITS-1:0]   qx_reg, qx_next;
    logic [Y_BITS-1:0]   qy_reg, qy_next;
    logic [Z_BITS-1:0]   qz_reg, qz_next;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        depth_next  = depth_reg;
        restart     = 1'b0;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WIDTH:
                begin
                    width_next = cfg_data[CFG_W_BITS-1:0];
                    restart    = 1'b1;
                end
                REG_HEIGHT:
                begin
                    height_next = cfg_data[CFG_H_BITS-1:0];
                    restart     = 1'b1;
                end
                REG_DEPTH:
                begin
                    depth_next = cfg_data[CFG_D_BITS-1:0];
                    restart    = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        w_c = CFG_W_BITS'(clamp_dim(CFG_D_BITS'(width_reg), CFG_D_BITS'(MAX_WIDTH)));
        h_c = CFG_H_BITS'(clamp_dim(CFG_D_BITS'(height_reg), CFG_D_BITS'(MAX_HEIGHT)));
        d_c = clamp_dim(depth_reg, CFG_D_BITS'(MAX_DEPTH));
        wh  = w_c * h_c;
        w_m1_next  = X_BITS'(w_c - 1'b1);
        h_m1_next  = Y_BITS'(h_c - 1'b1);
        d_m1_next  = Z_BITS'(d_c - 1'b1);
        wh_m1_next = PLANE_ADDR_BITS'(wh - 1'b1);
        lag_next   = LAG_BITS'(wh + (CFG_W_BITS+CFG_H_BITS)'(w_c) + 1'b1);
    end

    assign produce  = primed_reg || (fill_reg == lag_reg);
    assign bnd.x_dn = (qx_reg != '0);
    assign bnd.x_up = (qx_reg != w_m1_reg);
    assign bnd.y_dn = (qy_reg != '0);
    assign bnd.y_up = (qy_reg != h_m1_reg);
    assign bnd.z_dn = (qz_reg != '0);
    assign bnd.z_up = (qz_reg != d_m1_reg);
    assign bnd.last = !bnd.x_up && !bnd.y_up && !bnd.z_up;

    always_comb
    begin
        fill_next   = fill_reg;
        primed_next = primed_reg;
        qx_next     = qx_reg;
        qy_next     = qy_reg;
        qz_next     = qz_reg;
        if (restart)
        begin
            fill_next   = '0;
            primed_next = 1'b0;
            qx_next     = '0;
            qy_next     = '0;
            qz_next     = '0;
        end
        else if (adv)
        begin
            if (produce)
            begin
                if (bnd.last)
                begin
                    fill_next   = '0;
                    primed_next = 1'b0;
                    qx_next     = '0;
                    qy_next     = '0;
                    qz_next     = '0;
                end
                else
                begin
                    primed_next = 1'b1;
                    if (bnd.x_up)
                        qx_next = qx_reg + 1'b1;
                    else
                    begin
                        qx_next = '0;
                        if (bnd.y_up)
                            qy_next = qy_reg + 1'b1;
                        else
                        begin
                            qy_next = '0;
                            qz_next = qz_reg + 1'b1;
                        end
                    end
                end
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W_BITS'(RST_WIDTH);
            height_reg <= CFG_H_BITS'(RST_HEIGHT);
            depth_reg  <= CFG_D_BITS'(RST_DEPTH);
            w_m1_reg   <= X_BITS'(RST_WIDTH - 1);
            h_m1_reg   <= Y_BITS'(RST_HEIGHT - 1);
            d_m1_reg   <= Z_BITS'(RST_DEPTH - 1);
            wh_m1_reg  <= PLANE_ADDR_BITS'(RST_WIDTH * RST_HEIGHT - 1);
            lag_reg    <= LAG_BITS'(RST_WIDTH * RST_HEIGHT + RST_WIDTH + 1);
            fill_reg   <= '0;
            primed_reg <= 1'b0;
            qx_reg     <= '0;
            qy_reg     <= '0;
            qz_reg     <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            w_m1_reg   <= w_m1_next;
            h_m1_reg   <= h_m1_next;
            d_m1_reg   <= d_m1_next;
            wh_m1_reg  <= wh_m1_next;
            lag_reg    <= lag_next;
            fill_reg   <= fill_next;
            primed_reg <= primed_next;
            qx_reg     <= qx_next;
            qy_reg     <= qy_next;
            qz_reg     <= qz_next;
        end
    end

    assign w_m1  = w_m1_reg;
    assign wh_m1 = wh_m1_reg;

    a_idle_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> (qx_reg == '0 && qy_reg == '0 && qz_reg == '0))
        else $error("output coordinates moved before the window filled");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> (fill_reg <= lag_reg))
        else $error("fill count ran past the window lag");

    a_coord_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!restart) |-> (qx_reg <= w_m1_reg && qy_reg <= h_m1_reg && qz_reg <= d_m1_reg))
        else $error("output coordinate outside the volume");

endmodule

// ===== hdl/laplacian_3d_stencil_filter.sv =====
// Top level of the 3x3x3 Laplacian stencil filter: handshake, kernel sum, output register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  cfg      | cfg_wr_en            | cfg_index, cfg_data
//  in       | in_valid / in_stall  | voxel, drain
//  out      | out_valid / out_stall| filtered, last_voxel
//
// One voxel per cycle sustained unless the output stalls; after the transfer that completes
// its window, a result passes the window register stage, then the output register.
// The window advances only on an input transfer; in_stall rises only while the
// window holds a result and the output register is full and stalled.
// Reset clears control state only; delay-line contents are don't-care until written.
module laplacian_3d_stencil_filter
    import l3d_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [SAMPLE_BITS-1:0]     voxel,
    input  logic                       drain,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [OUT_BITS-1:0] filtered,
    output logic                       last_voxel
);

    localparam int ROW_BITS   = SAMPLE_BITS + 2;
    localparam int PLANE_BITS = SAMPLE_BITS + 4;

    logic                       adv;
    logic                       s1_move;
    logic                       produce;
    bound_t                     bnd;
    logic [X_BITS-1:0]          w_m1;
    logic [PLANE_ADDR_BITS-1:0] wh_m1;
    sample_t                    sample;
    window_t                    taps;

    logic   s1_valid_reg, s1_valid_next;
    bound_t s1_bnd_reg;

    logic                       out_valid_reg;
    logic signed [OUT_BITS-1:0] filtered_reg;
    logic                       last_reg;

    logic [2:0]                 z_ok, y_ok, x_ok;
    sample_t                    nb [3][3][3];
    logic [ROW_BITS-1:0]        row_sum [3][3];
    logic [PLANE_BITS-1:0]      plane_sum [3];
    logic [OUT_BITS-2:0]        nsum;
    logic [OUT_BITS-2:0]        c26;
    logic signed [OUT_BITS-1:0] filt_next;

    assign s1_move  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_move;
    assign adv      = in_valid && !in_stall;
    assign sample   = drain ? '0 : voxel;

    l3d_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .adv       (adv),
        .produce   (produce),
        .bnd       (bnd),
        .w_m1      (w_m1),
        .wh_m1     (wh_m1)
    );

    l3d_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .sample (sample),
        .w_m1   (w_m1),
        .wh_m1  (wh_m1),
        .taps   (taps)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (adv)
            s1_valid_next = produce;
        else if (s1_move)
            s1_valid_next = 1'b0;
    end

    // zero padding: drop taps that fall outside the volume
    always_comb
    begin
        z_ok = {s1_bnd_reg.z_dn, 1'b1, s1_bnd_reg.z_up};
        y_ok = {s1_bnd_reg.y_dn, 1'b1, s1_bnd_reg.y_up};
        x_ok = {s1_bnd_reg.x_dn, 1'b1, s1_bnd_reg.x_up};
        for (int j = 0; j < 3; j++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (z_ok[j] && y_ok[r] && x_ok[c] && !(j == 1 && r == 1 && c == 1))
                        nb[j][r][c] = taps[j][r][c];
                    else
                        nb[j][r][c] = '0;
                end
                row_sum[j][r] = ROW_BITS'(nb[j][r][0]) + ROW_BITS'(nb[j][r][1])
                              + ROW_BITS'(nb[j][r][2]);
            end
            plane_sum[j] = PLANE_BITS'(row_sum[j][0]) + PLANE_BITS'(row_sum[j][1])
                         + PLANE_BITS'(row_sum[j][2]);
        end
        nsum = (OUT_BITS-1)'(plane_sum[0]) + (OUT_BITS-1)'(plane_sum[1])
             + (OUT_BITS-1)'(plane_sum[2]);
        c26  = ((OUT_BITS-1)'(taps[1][1][1]) << 4) + ((OUT_BITS-1)'(taps[1][1][1]) << 3)
             + ((OUT_BITS-1)'(taps[1][1][1]) << 1);
        filt_next = $signed({1'b0, c26}) - $signed({1'b0, nsum});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_move)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && produce)
            s1_bnd_reg <= bnd;
        if (s1_move && s1_valid_reg)
        begin
            filtered_reg <= filt_next;
            last_reg     <= s1_bnd_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign filtered   = filtered_reg;
    assign last_voxel = last_reg;

endmodule

// ===== test/tb_laplacian_3d_stencil_filter.sv =====
// Testbench for the 3x3x3 Laplacian stencil filter: streamed volumes checked against a predictor.
module tb_laplacian_3d_stencil_filter
    import l3d_pkg::*;
();

    localparam int HIST_DEPTH     = 2 * MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 1900;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] filtered;
        logic                       last;
    } laplace_out_t;

    typedef enum int {FILL_UNIFORM, FILL_EXTREMES, FILL_DARK_SPOT} fill_t;

    class laplace_scoreboard;
        sample_t      history [HIST_DEPTH];
        int           width_reg;
        int           height_reg;
        int           depth_reg;
        int           in_pos;
        int           out_pos;
        laplace_out_t expected [$];
        int           mismatches;

        function new();
            width_reg  = RST_WIDTH;
            height_reg = RST_HEIGHT;
            depth_reg  = RST_DEPTH;
            in_pos     = 0;
            out_pos    = 0;
            mismatches = 0;
            foreach (history[i])
                history[i] = '0;
        endfunction

        function int bound(int v, int hi);
            if (v < 1)
                return 1;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_WIDTH:  width_reg  = int'(data[CFG_W_BITS-1:0]);
                REG_HEIGHT: height_reg = int'(data[CFG_H_BITS-1:0]);
                REG_DEPTH:  depth_reg  = int'(data[CFG_D_BITS-1:0]);
                default:    return;
            endcase
            in_pos  = 0;
            out_pos = 0;
        endfunction

        function int laplacian_at(int q, int w, int h, int d);
            int x, y, z, xx, yy, zz, v, sum;
            x   = q % w;
            y   = (q / w) % h;
            z   = q / (w * h);
            sum = 0;
            for (int dz = -1; dz <= 1; dz++)
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++)
                    begin
                        zz = z + dz;
                        yy = y + dy;
                        xx = x + dx;
                        if (zz < 0 || zz >= d || yy < 0 || yy >= h || xx < 0 || xx >= w)
                            continue;
                        v = int'(history[((zz * h + yy) * w + xx) % HIST_DEPTH]);
                        if (dz == 0 && dy == 0 && dx == 0)
                            sum += 26 * v;
                        else
                            sum -= v;
                    end
            return sum;
        endfunction

        function void note_input(sample_t v, logic is_drain);
            int w, h, d, total, lag, p, val;
            laplace_out_t r;
            w     = bound(width_reg, MAX_WIDTH);
            h     = bound(height_reg, MAX_HEIGHT);
            d     = bound(depth_reg, MAX_DEPTH);
            total = w * h * d;
            lag   = w * h + w + 1;
            p     = in_pos;
            if (p < total)
                history[p % HIST_DEPTH] = is_drain ? '0 : v;
            in_pos = p + 1;
            if (p < lag)
                return;
            val        = laplacian_at(out_pos, w, h, d);
            r.filtered = val[OUT_BITS-1:0];
            r.last     = (out_pos + 1 >= total);
            expected.push_back(r);
            out_pos = out_pos + 1;
            if (r.last)
            begin
                in_pos  = 0;
                out_pos = 0;
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function void check(logic signed [OUT_BITS-1:0] f, logic l);
            laplace_out_t want;
            if (expected.size() == 0)
            begin
                flag($sformatf("unexpected result filtered=%0d last_voxel=%0b", f, l));
                return;
            end
            want = expected.pop_front();
            if (f !== want.filtered)
                flag($sformatf("filtered expected %0d got %0d", want.filtered, f));
            if (l !== want.last)
                flag($sformatf("last_voxel expected %0b got %0b", want.last, l));
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [1:0]                 cfg_index = REG_WIDTH;
    logic [CFG_DATA_BITS-1:0]   cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    sample_t                    voxel     = '0;
    logic                       drain     = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [OUT_BITS-1:0] filtered;
    logic                       last_voxel;

    laplace_scoreboard sb;
    int quiet_cycles = 0;
    int items_sent   = 0;
    int burst_left   = 0;
    int hold_reqs    = 0;
    int holds_done   = 0;
    int vol_w, vol_h, vol_d, vol_total, vol_lag;

    laplacian_3d_stencil_filter DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .voxel      (voxel),
        .drain      (drain),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .filtered   (filtered),
        .last_voxel (last_voxel)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (cfg_wr_en)
            sb.write_reg(cfg_index, cfg_data);
        if (in_valid && !in_stall)
            sb.note_input(voxel, drain);
        if (out_valid && !out_stall)
            sb.check(filtered, last_voxel);
        if (cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // output side: random stalls, free-running stretches, one long hold on request
    initial
    begin
        int n;
        @(posedge clk);
        forever
        begin
            if (hold_reqs != holds_done)
            begin
                holds_done++;
                n = HOLD_CYCLES;
            end
            else
                n = pick_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            if ($urandom_range(7) == 0)
                n = $urandom_range(30, 150);
            else
                n = $urandom_range(0, 4);
            repeat (1 + n) @(posedge clk);
        end
    end

    task automatic offer(sample_t v, logic d);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(39) == 0)
                burst_left = $urandom_range(20, 150);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        voxel    <= v;
        drain    <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_volume(int w, int h, int d);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= CFG_DATA_BITS'(w);
        @(posedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= CFG_DATA_BITS'(h);
        @(posedge clk);
        cfg_index <= REG_DEPTH;
        cfg_data  <= CFG_DATA_BITS'(d);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        vol_w     = sb.bound(int'(w[CFG_W_BITS-1:0]), MAX_WIDTH);
        vol_h     = sb.bound(int'(h[CFG_H_BITS-1:0]), MAX_HEIGHT);
        vol_d     = sb.bound(int'(d[CFG_D_BITS-1:0]), MAX_DEPTH);
        vol_total = vol_w * vol_h * vol_d;
        vol_lag   = vol_w * vol_h + vol_w + 1;
    endtask

    // voxels in raster order, then the flush items; a cut between 0 and the span stops early
    task automatic send_volume(fill_t fill, int cut);
        int span;
        sample_t v;
        logic d;
        span = vol_total + vol_lag;
        if (cut > 0 && cut < span)
            span = cut;
        for (int p = 0; p < span; p++)
        begin
            if (p < vol_total)
            begin
                d = (fill != FILL_DARK_SPOT) && ($urandom_range(19) == 0);
                case (fill)
                    FILL_UNIFORM:  v = sample_t'($urandom_range(SAMPLE_MAX));
                    FILL_EXTREMES: v = sample_t'($urandom_range(1) ? SAMPLE_MAX : 0);
                    default:       v = sample_t'((p == vol_total / 2) ? 0 : SAMPLE_MAX);
                endcase
            end
            else
            begin
                d = ($urandom_range(9) < 7);
                v = sample_t'($urandom_range(SAMPLE_MAX));
            end
            offer(v, d);
        end
    endtask

    initial
    begin
        int w, h, d, nvol, cut, r;
        fill_t fill;
        logic squeeze;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short of the first result, then restarted by the register writes
        offer(sample_t'(SAMPLE_MAX), 1'b0);
        offer('0, 1'b0);
        offer(sample_t'(SAMPLE_MAX), 1'b1);
        wait_idle();

        // 2x2x2: one bright voxel, a drain inside the volume, voxels during the flush
        write_volume(2, 2, 2);
        for (int p = 0; p < 15; p++)
            offer(sample_t'((p == 0 || p == 2 || (p >= 8 && p % 2 == 1)) ? SAMPLE_MAX : 0),
                  (p == 2) || (p >= 8 && p % 2 == 0));
        wait_idle();

        for (int setting = 0; items_sent < ITEM_TARGET; setting++)
        begin
            squeeze = 1'b0;
            nvol    = 1;
            fill    = FILL_UNIFORM;
            case (setting)
                0:
                begin
                    w = 3; h = 3; d = 3;
                    fill = FILL_DARK_SPOT;
                end
                1:
                begin
                    w = 1; h = 1; d = 2047;
                    squeeze = 1'b1;
                end
                2:
                begin
                    w = 2047; h = 1; d = 2;
                end
                3:
                begin
                    w = 1; h = 2047; d = 1;
                    fill = FILL_EXTREMES;
                end
                4:
                begin
                    w = 0; h = 0; d = 0;
                    nvol = 3;
                end
                default:
                begin
                    w    = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
                    h    = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 5);
                    d    = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
                    nvol = $urandom_range(1, 3);
                    r    = $urandom_range(9);
                    fill = (r < 6) ? FILL_UNIFORM : (r < 9) ? FILL_EXTREMES : FILL_DARK_SPOT;
                end
            endcase
            write_volume(w, h, d);
            if (squeeze)
            begin
                burst_left = 1 << 20;
                hold_reqs++;
            end
            for (int n = 0; n < nvol; n++)
            begin
                cut = 0;
                if (!squeeze && $urandom_range(9) == 0)
                    cut = $urandom_range(1, vol_total + vol_lag - 1);
                send_volume(fill, cut);
                if (cut != 0)
                    break;
            end
            burst_left = 0;
            wait_idle();
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/l3d_pkg.sv
hdl/l3d_delay_ram.sv
hdl/l3d_window.sv
hdl/l3d_seq.sv
hdl/laplacian_3d_stencil_filter.sv
test/tb_laplacian_3d_stencil_filter.sv
